[sv/mcct_pkg.sv]
// shared types and constants of the multi-channel countdown timer
// no dependencies; imported by every other file of the block

package mcct_pkg;

    localparam int CHANNELS_DEFAULT = 4;
    localparam int MAX_CHANNELS     = 16;

    localparam int OP_W    = 3;
    localparam int CHAN_W  = 2;
    localparam int COUNT_W = 32;
    localparam int MASK_W  = 4;

    localparam logic [COUNT_W-1:0] TICKS_MAX = {COUNT_W{1'b1}};

    typedef enum logic [OP_W-1:0] {
        OP_TICK      = 3'd0,
        OP_ARM       = 3'd1,
        OP_REARM     = 3'd2,
        OP_FIND_FREE = 3'd3,
        OP_RELEASE   = 3'd4
    } op_t;

    typedef struct packed {
        op_t                op;
        logic [CHAN_W-1:0]  channel;
        logic [COUNT_W-1:0] ticks;
        logic               tick_en;
        logic [MASK_W-1:0]  hook_mask;
        logic               fire;
    } bank_cmd_t;

    typedef struct packed {
        logic [MASK_W-1:0] fired;
        logic [MASK_W-1:0] done;
        logic              any_next;
        logic              busy;
        logic              free_found;
        logic [CHAN_W-1:0] free_index;
    } bank_stat_t;

endpackage

[sv/mcct_req_if.sv]
// request channel of the countdown timer: valid/ready plus operation fields
// depends on mcct_pkg

interface mcct_req_if
    import mcct_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [OP_W-1:0]    operation;
    logic [CHAN_W-1:0]  channel;
    logic [COUNT_W-1:0] ticks;

    modport source (output valid, output operation, output channel, output ticks,
                    input ready);
    modport sink   (input valid, input operation, input channel, input ticks,
                    output ready);
endinterface

[sv/mcct_rsp_if.sv]
// response channel of the countdown timer: valid/ready plus status fields
// depends on mcct_pkg

interface mcct_rsp_if
    import mcct_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [MASK_W-1:0]  fired_mask;
    logic [MASK_W-1:0]  done_flags;
    logic               irq_enabled;
    logic [COUNT_W-1:0] tick_count;
    logic               free_found;
    logic [CHAN_W-1:0]  free_index;

    modport source (output valid, output fired_mask, output done_flags,
                    output irq_enabled, output tick_count, output free_found,
                    output free_index, input ready);
    modport sink   (input valid, input fired_mask, input done_flags,
                    input irq_enabled, input tick_count, input free_found,
                    input free_index, output ready);
endinterface

[sv/mcct_bank.sv]
// channel bank: count, reload and done state of every channel, updated in parallel
// depends on mcct_pkg

module mcct_bank
    import mcct_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,
    input  bank_cmd_t  cmd,
    output bank_stat_t stat
);

    logic [COUNT_W-1:0] cnt_reg  [CHANNELS];
    logic [COUNT_W-1:0] cnt_next [CHANNELS];
    logic [COUNT_W-1:0] rld_reg  [CHANNELS];
    logic [COUNT_W-1:0] rld_next [CHANNELS];
    logic [CHANNELS-1:0] done_reg;
    logic [CHANNELS-1:0] done_next;
    logic [CHANNELS-1:0] fired_vec;
    logic [CHANNELS-1:0] nz_next;
    logic [CHANNELS-1:0] nz_cur;
    logic [MAX_CHANNELS-1:0] hook_ext;
    logic [MAX_CHANNELS-1:0] done_ext;
    logic [MAX_CHANNELS-1:0] fired_ext;
    logic [COUNT_W-1:0] load_val;
    logic               ch_ok;
    logic               found;
    logic [CHAN_W-1:0]  idx;

    assign hook_ext = MAX_CHANNELS'(cmd.hook_mask);
    assign load_val = (cmd.ticks == TICKS_MAX) ? cmd.ticks : cmd.ticks + 1'b1;
    assign ch_ok    = 32'(cmd.channel) < 32'(CHANNELS);

    for (genvar n = 0; n < CHANNELS; n++) begin : g_chan
        localparam bit HAS_HOOK = (n < MASK_W);
        logic sel;

        assign sel = ch_ok && (32'(cmd.channel) == 32'(n));

        always_comb
        begin
            cnt_next[n]  = cnt_reg[n];
            rld_next[n]  = rld_reg[n];
            done_next[n] = done_reg[n];
            fired_vec[n] = 1'b0;
            unique case (cmd.op)
                OP_TICK:
                begin
                    if (cmd.tick_en && cnt_reg[n] != '0)
                    begin
                        cnt_next[n] = cnt_reg[n] - 1'b1;
                        if (cnt_reg[n] == COUNT_W'(1))
                        begin
                            if (HAS_HOOK && hook_ext[n])
                                fired_vec[n] = 1'b1;
                            else
                                done_next[n] = 1'b1;
                        end
                    end
                end
                OP_ARM:
                begin
                    if (sel)
                    begin
                        done_next[n] = 1'b0;
                        rld_next[n]  = load_val;
                        cnt_next[n]  = load_val;
                    end
                end
                OP_REARM:
                begin
                    if (sel)
                        cnt_next[n] = rld_reg[n];
                end
                OP_RELEASE:
                begin
                    if (sel)
                        rld_next[n] = '0;
                end
                default:
                begin
                end
            endcase
        end

        assign nz_next[n] = cnt_next[n] != '0;
        assign nz_cur[n]  = cnt_reg[n] != '0;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                cnt_reg[n]  <= '0;
                rld_reg[n]  <= '0;
                done_reg[n] <= 1'b0;
            end
            else if (cmd.fire)
            begin
                cnt_reg[n]  <= cnt_next[n];
                rld_reg[n]  <= rld_next[n];
                done_reg[n] <= done_next[n];
            end
        end
    end

    // lowest channel with a zero reload
    always_comb
    begin
        found = 1'b0;
        idx   = '0;
        for (int i = CHANNELS - 1; i >= 0; i--)
        begin
            if (rld_reg[i] == '0)
            begin
                found = 1'b1;
                idx   = CHAN_W'(i);
            end
        end
    end

    assign done_ext  = MAX_CHANNELS'(done_next);
    assign fired_ext = MAX_CHANNELS'(fired_vec);

    always_comb
    begin
        stat.fired      = fired_ext[MASK_W-1:0];
        stat.done       = done_ext[MASK_W-1:0];
        stat.any_next   = |nz_next;
        stat.busy       = |nz_cur;
        stat.free_found = (cmd.op == OP_FIND_FREE) && found;
        stat.free_index = ((cmd.op == OP_FIND_FREE) && found) ? idx : '0;
    end

endmodule

[sv/multi_channel_countdown_timer.sv]
// top level of the multi-channel countdown timer: request and response stages,
// timestamp, interrupt enable and hook mask; depends on mcct_pkg, the channel
// interfaces and mcct_bank
//
// usage:
//   req carries one operation per transaction (tick, arm, rearm, find_free,
//   release); rsp returns exactly one status transaction for each of them,
//   in order. cfg_we/cfg_wdata write the hook mask; write it only while idle.
//   path: a request accepted into the input register reaches rsp from the
//   result register (one input register, one result register).
//   throughput: one transaction per cycle while rsp accepts, each taking a
//   single pass through the channel bank update between the two registers.
//   reset: all counts, reloads, done flags, the timestamp, the interrupt
//   enable and the hook mask are cleared; both stages come up empty.
//   stall: while rsp is held off, the result register keeps its value and
//   the input register still takes one more request; req.ready drops only
//   when both registers are full.

module multi_channel_countdown_timer
    import mcct_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    mcct_req_if.sink          req,
    mcct_rsp_if.source        rsp,
    input  logic              cfg_we,
    input  logic [MASK_W-1:0] cfg_wdata
);

    logic               in_vld_reg;
    logic [OP_W-1:0]    op_reg;
    logic [CHAN_W-1:0]  ch_reg;
    logic [COUNT_W-1:0] ticks_reg;

    logic               out_vld_reg;
    logic [MASK_W-1:0]  fired_reg;
    logic [MASK_W-1:0]  done_reg;
    logic               irq_out_reg;
    logic [COUNT_W-1:0] ts_out_reg;
    logic               found_reg;
    logic [CHAN_W-1:0]  index_reg;

    logic [MASK_W-1:0]  hook_reg;
    logic               irq_reg;
    logic               irq_next;
    logic [COUNT_W-1:0] ts_reg;
    logic [COUNT_W-1:0] ts_next;

    logic       adv;
    logic       fire;
    op_t        op;
    bank_cmd_t  cmd;
    bank_stat_t stat;

    assign adv       = !out_vld_reg || rsp.ready;
    assign fire      = in_vld_reg && adv;
    assign req.ready = !in_vld_reg || adv;
    assign op        = op_t'(op_reg);

    always_comb
    begin
        cmd.op        = op;
        cmd.channel   = ch_reg;
        cmd.ticks     = ticks_reg;
        cmd.tick_en   = irq_reg;
        cmd.hook_mask = hook_reg;
        cmd.fire      = fire;
    end

    mcct_bank #(
        .CHANNELS (CHANNELS)
    ) u_bank (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .stat  (stat)
    );

    always_comb
    begin
        irq_next = irq_reg;
        ts_next  = ts_reg;
        unique case (op)
            OP_TICK:
            begin
                if (irq_reg)
                begin
                    ts_next = ts_reg + 1'b1;
                    if (!stat.any_next)
                        irq_next = 1'b0;
                end
            end
            OP_ARM, OP_REARM:
            begin
                if (32'(ch_reg) < 32'(CHANNELS))
                    irq_next = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (req.ready)
            in_vld_reg <= req.valid;
    end

    always_ff @(posedge clk)
    begin
        if (req.ready && req.valid)
        begin
            op_reg    <= req.operation;
            ch_reg    <= req.channel;
            ticks_reg <= req.ticks;
        end
    end

    // timer state and hook mask
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            irq_reg  <= 1'b0;
            ts_reg   <= '0;
            hook_reg <= '0;
        end
        else
        begin
            if (fire)
            begin
                irq_reg <= irq_next;
                ts_reg  <= ts_next;
            end
            if (cfg_we)
                hook_reg <= cfg_wdata;
        end
    end

    // result stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (adv)
            out_vld_reg <= in_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            fired_reg   <= stat.fired;
            done_reg    <= stat.done;
            irq_out_reg <= irq_next;
            ts_out_reg  <= ts_next;
            found_reg   <= stat.free_found;
            index_reg   <= stat.free_index;
        end
    end

    assign rsp.valid       = out_vld_reg;
    assign rsp.fired_mask  = fired_reg;
    assign rsp.done_flags  = done_reg;
    assign rsp.irq_enabled = irq_out_reg;
    assign rsp.tick_count  = ts_out_reg;
    assign rsp.free_found  = found_reg;
    assign rsp.free_index  = index_reg;

`ifndef NO_ASSERTIONS
    // counting stops only once every channel has run down
    a_idle_means_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !irq_reg |-> !stat.busy)
        else $error("interrupt enable clear while a channel is still counting");

    // the timestamp moves only on a counted tick
    a_ts_only_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
        ts_reg != $past(ts_reg) |-> $past(fire && op == OP_TICK && irq_reg))
        else $error("timestamp changed without a counted tick");

    // a free slot of the result stage always lets a request in
    a_ready_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_vld_reg |-> req.ready)
        else $error("request stalled although the result stage is empty");

    // no free index reported without a free channel
    a_index_needs_found: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && !found_reg |-> index_reg == '0)
        else $error("free index set without a free channel");
`endif

endmodule

[sim/multi_channel_countdown_timer_test.sv]
// self-checking bench for multi_channel_countdown_timer: a directed table,
// then random operations under several hook masks, checked against a predictor
// depends on mcct_pkg, mcct_req_if, mcct_rsp_if and the timer rtl

`timescale 1ns / 100ps

module multi_channel_countdown_timer_test;
    import mcct_pkg::*;

    localparam int NUM_CH        = CHANNELS_DEFAULT;
    localparam int OPENING_ROWS  = 25;
    localparam int PHASES        = 5;
    localparam int PHASE_ITEMS   = 85;
    localparam int SETTLE_CYCLES = 4;
    localparam int HOLD_AFTER    = 120;
    localparam int HOLD_CYCLES   = 60;
    localparam int CYCLE_LIMIT   = 200000;

    localparam logic [OP_W-1:0] OP_SPARE_LO  = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE_MID = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_HI  = 3'd7;

    typedef struct packed {
        logic [MASK_W-1:0]  fired;
        logic [MASK_W-1:0]  done;
        logic               irq;
        logic [COUNT_W-1:0] tstamp;
        logic               found;
        logic [CHAN_W-1:0]  idx;
    } timer_status_t;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [CHAN_W-1:0]  ch;
        logic [COUNT_W-1:0] ticks;
        logic               typed;
        timer_status_t      status;
    } timer_row_t;

    typedef enum int {RX_OPEN, RX_PATTERN, RX_RANDOM} rx_mode_t;

    localparam timer_status_t NO_STATUS = '0;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we;
    logic [MASK_W-1:0] cfg_wdata;

    mcct_req_if req_ch ();
    mcct_rsp_if rsp_ch ();

    multi_channel_countdown_timer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // predictor state
    logic [COUNT_W-1:0] count_q  [NUM_CH] = '{default: '0};
    logic [COUNT_W-1:0] reload_q [NUM_CH] = '{default: '0};
    logic [MASK_W-1:0]  done_q    = '0;
    logic [COUNT_W-1:0] tstamp_q  = '0;
    logic               irq_en_q  = 1'b0;
    logic [MASK_W-1:0]  hook_mask = '0;

    timer_status_t pending_status [$];
    int mismatches    = 0;
    int sent_count    = 0;
    int burst_left    = 0;
    int cycles        = 0;
    bit pressure_done = 1'b0;

    timer_row_t opening_rows [OPENING_ROWS] = '{
        '{OP_TICK,      2'd0, 32'd0,         1'b1, '{4'h0, 4'h0, 1'b0, 32'd0, 1'b0, 2'd0}},
        '{OP_FIND_FREE, 2'd0, 32'd0,         1'b1, '{4'h0, 4'h0, 1'b0, 32'd0, 1'b1, 2'd0}},
        '{OP_SPARE_LO,  2'd3, TICKS_MAX,     1'b1, '{4'h0, 4'h0, 1'b0, 32'd0, 1'b0, 2'd0}},
        '{OP_SPARE_HI,  2'd1, 32'd0,         1'b1, '{4'h0, 4'h0, 1'b0, 32'd0, 1'b0, 2'd0}},
        '{OP_ARM,       2'd0, 32'd0,         1'b1, '{4'h0, 4'h0, 1'b1, 32'd0, 1'b0, 2'd0}},
        '{OP_ARM,       2'd1, 32'd1,         1'b1, '{4'h0, 4'h0, 1'b1, 32'd0, 1'b0, 2'd0}},
        '{OP_FIND_FREE, 2'd0, 32'd0,         1'b1, '{4'h0, 4'h0, 1'b1, 32'd0, 1'b1, 2'd2}},
        '{OP_TICK,      2'd0, 32'd0,         1'b1, '{4'h0, 4'h1, 1'b1, 32'd1, 1'b0, 2'd0}},
        '{OP_TICK,      2'd0, 32'd0,         1'b1, '{4'h2, 4'h1, 1'b0, 32'd2, 1'b0, 2'd0}},
        '{OP_TICK,      2'd0, 32'd0,         1'b1, '{4'h0, 4'h1, 1'b0, 32'd2, 1'b0, 2'd0}},
        '{OP_REARM,     2'd2, 32'd0,         1'b1, '{4'h0, 4'h1, 1'b1, 32'd2, 1'b0, 2'd0}},
        '{OP_TICK,      2'd0, 32'd0,         1'b1, '{4'h0, 4'h1, 1'b0, 32'd3, 1'b0, 2'd0}},
        '{OP_ARM,       2'd3, TICKS_MAX,     1'b1, '{4'h0, 4'h1, 1'b1, 32'd3, 1'b0, 2'd0}},
        '{OP_ARM,       2'd2, TICKS_MAX - 1, 1'b0, NO_STATUS},
        '{OP_RELEASE,   2'd3, 32'd0,         1'b0, NO_STATUS},
        '{OP_FIND_FREE, 2'd0, 32'd0,         1'b1, '{4'h0, 4'h1, 1'b1, 32'd3, 1'b1, 2'd3}},
        '{OP_ARM,       2'd3, 32'd0,         1'b0, NO_STATUS},
        '{OP_FIND_FREE, 2'd0, 32'd0,         1'b1, '{4'h0, 4'h1, 1'b1, 32'd3, 1'b0, 2'd0}},
        '{OP_ARM,       2'd0, 32'd2,         1'b0, NO_STATUS},
        '{OP_TICK,      2'd0, 32'd0,         1'b0, NO_STATUS},
        '{OP_REARM,     2'd1, 32'd0,         1'b0, NO_STATUS},
        '{OP_TICK,      2'd0, 32'd0,         1'b0, NO_STATUS},
        '{OP_RELEASE,   2'd2, 32'd0,         1'b0, NO_STATUS},
        '{OP_SPARE_MID, 2'd2, 32'h5555_5555, 1'b0, NO_STATUS},
        '{OP_FIND_FREE, 2'd0, 32'd0,         1'b0, NO_STATUS}
    };

    function automatic timer_status_t advance_timer(input logic [OP_W-1:0] op,
                                                    input logic [CHAN_W-1:0] ch,
                                                    input logic [COUNT_W-1:0] ticks);
        timer_status_t st;
        logic [COUNT_W-1:0] load;
        logic any_left;
        st = '0;
        case (op)
            OP_TICK:
            begin
                if (irq_en_q)
                begin
                    any_left = 1'b0;
                    tstamp_q = tstamp_q + 1;
                    for (int n = 0; n < NUM_CH; n++)
                    begin
                        if (count_q[n] != '0)
                        begin
                            count_q[n] = count_q[n] - 1;
                            if (count_q[n] == '0)
                            begin
                                if (hook_mask[n])
                                    st.fired[n] = 1'b1;
                                else
                                    done_q[n] = 1'b1;
                            end
                        end
                        if (count_q[n] != '0)
                            any_left = 1'b1;
                    end
                    if (!any_left)
                        irq_en_q = 1'b0;
                end
            end
            OP_ARM:
            begin
                load = (ticks == TICKS_MAX) ? TICKS_MAX : ticks + 1;
                done_q[ch]   = 1'b0;
                reload_q[ch] = load;
                count_q[ch]  = load;
                irq_en_q     = 1'b1;
            end
            OP_REARM:
            begin
                count_q[ch] = reload_q[ch];
                irq_en_q    = 1'b1;
            end
            OP_FIND_FREE:
            begin
                for (int n = 0; n < NUM_CH; n++)
                begin
                    if (!st.found && reload_q[n] == '0)
                    begin
                        st.found = 1'b1;
                        st.idx   = CHAN_W'(n);
                    end
                end
            end
            OP_RELEASE:
                reload_q[ch] = '0;
            default:
                ;
        endcase
        st.done   = done_q;
        st.irq    = irq_en_q;
        st.tstamp = tstamp_q;
        return st;
    endfunction

    // burst pacing of the request side, called at a falling edge
    task automatic pace_sender();
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                req_ch.valid = 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
    endtask

    task automatic send_item(input logic [OP_W-1:0] op, input logic [CHAN_W-1:0] ch,
                             input logic [COUNT_W-1:0] ticks, input logic typed,
                             input timer_status_t typed_status);
        timer_status_t st;
        pace_sender();
        req_ch.operation = op;
        req_ch.channel   = ch;
        req_ch.ticks     = ticks;
        req_ch.valid     = 1'b1;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        st = advance_timer(op, ch, ticks);
        pending_status.push_back(typed ? typed_status : st);
        sent_count++;
        @(negedge clk);
    endtask

    task automatic send_random_item();
        int r;
        logic [OP_W-1:0] op;
        logic [COUNT_W-1:0] ticks;
        r = $urandom_range(0, 99);
        if (r < 45)
            op = OP_TICK;
        else if (r < 70)
            op = OP_ARM;
        else if (r < 80)
            op = OP_REARM;
        else if (r < 88)
            op = OP_FIND_FREE;
        else if (r < 96)
            op = OP_RELEASE;
        else
            op = OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
        r = $urandom_range(0, 99);
        if (r < 70)
            ticks = $urandom_range(0, 6);
        else if (r < 85)
            ticks = $urandom_range(7, 60);
        else if (r < 93)
            ticks = $urandom;
        else if (r < 97)
            ticks = TICKS_MAX;
        else
            ticks = TICKS_MAX - 1;
        send_item(op, CHAN_W'($urandom_range(0, NUM_CH - 1)), ticks, 1'b0, NO_STATUS);
    endtask

    task automatic write_hook_mask(input logic [MASK_W-1:0] m);
        cfg_wdata = m;
        cfg_we    = 1'b1;
        @(negedge clk);
        cfg_we    = 1'b0;
        hook_mask = m;
    endtask

    task automatic drain_results();
        req_ch.valid = 1'b0;
        while (pending_status.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic check_field(input string field, input logic [COUNT_W-1:0] want,
                               input logic [COUNT_W-1:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", field, want, got);
            mismatches++;
        end
    endtask

    // result checking
    always @(posedge clk)
    begin
        timer_status_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_status.size() == 0)
            begin
                $error("status transaction with no request outstanding");
                mismatches++;
            end
            else
            begin
                want = pending_status.pop_front();
                check_field("fired_mask", want.fired, rsp_ch.fired_mask);
                check_field("done_flags", want.done, rsp_ch.done_flags);
                check_field("irq_enabled", want.irq, rsp_ch.irq_enabled);
                check_field("tick_count", want.tstamp, rsp_ch.tick_count);
                check_field("free_found", want.found, rsp_ch.free_found);
                check_field("free_index", want.idx, rsp_ch.free_index);
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // response side: open, patterned and random stalls, plus one long hold-off
    initial
    begin
        int span;
        logic [7:0] pat;
        rx_mode_t mode;
        rsp_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (!pressure_done && sent_count >= HOLD_AFTER)
            begin
                @(negedge clk);
                rsp_ch.ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                pressure_done = 1'b1;
            end
            else
            begin
                mode = rx_mode_t'($urandom_range(0, 2));
                span = $urandom_range(8, 48);
                pat  = $urandom;
                for (int c = 0; c < span; c++)
                begin
                    @(negedge clk);
                    case (mode)
                        RX_OPEN:    rsp_ch.ready = 1'b1;
                        RX_PATTERN: rsp_ch.ready = pat[c % 8];
                        default:    rsp_ch.ready = ($urandom_range(0, 2) != 0);
                    endcase
                end
            end
        end
    end

    initial
    begin
        logic [MASK_W-1:0] phase_masks [PHASES];
        req_ch.valid     = 1'b0;
        req_ch.operation = '0;
        req_ch.channel   = '0;
        req_ch.ticks     = '0;
        cfg_we           = 1'b0;
        cfg_wdata        = '0;
        phase_masks = '{4'hF, 4'h0, 4'h5, 4'hC, MASK_W'($urandom_range(0, 15))};

        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        write_hook_mask(4'b1010);
        for (int i = 0; i < OPENING_ROWS; i++)
            send_item(opening_rows[i].op, opening_rows[i].ch, opening_rows[i].ticks,
                      opening_rows[i].typed, opening_rows[i].status);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            drain_results();
            write_hook_mask(phase_masks[ph]);
            for (int i = 0; i < PHASE_ITEMS; i++)
                send_random_item();
        end
        drain_results();

        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
